// ----- design/dfu_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfu_pkg
// Shared types and constants for the digitizer frame unpacker.
// ----------------------------------------------------------------------------
package dfu_pkg;

	localparam int CHANNELS_PER_MODULE_DEF = 64;
	localparam int HEADER_WORDS            = 3;
	localparam int CHAN_COUNT_W            = 14;

	// result kinds
	localparam logic [1:0] KIND_HEADER = 2'd0;
	localparam logic [1:0] KIND_PAIR   = 2'd1;
	localparam logic [1:0] KIND_REJECT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_MAX_MODULES = 2'd0;
	localparam logic [1:0] CFG_MAX_SAMPLES = 2'd1;
	localparam logic [1:0] CFG_MAX_SLOT    = 2'd2;

	localparam logic [2:0] MAX_MODULES_RST = 3'd5;
	localparam logic [4:0] MAX_SAMPLES_RST = 5'd31;
	localparam logic [7:0] MAX_SLOT_RST    = 8'd22;

	typedef struct packed {
		logic [31:0] data_word;
		logic        frame_start;
	} word_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [4:0]              sample_index;
		logic [8:0]              channel_index;
		logic [15:0]             value_even;
		logic [15:0]             value_odd;
		logic [7:0]              sample_count;
		logic [7:0]              trigger_delay;
		logic [7:0]              slot_number;
		logic [7:0]              module_count;
		logic [CHAN_COUNT_W-1:0] channel_count;
		logic [15:0]             clock_stamp;
		logic [15:0]             event_number;
	} result_t;

	typedef struct packed {
		logic [2:0] max_modules;
		logic [4:0] max_samples;
		logic [7:0] max_slot;
	} cfg_t;

endpackage
`default_nettype wire

// ----- design/digitizer_frame_unpacker_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// digitizer_frame_unpacker_core
// Unpacks digitizer subevent words into header and sample pair results.
// ----------------------------------------------------------------------------
// Takes one 32-bit word per cycle and gives at most one result per word.
// A word is held in the input register, where it is decoded against the
// frame state, and its result then goes to the result register. The frame
// state updates as the word is decoded, so words stream back to back at
// one per cycle; a stalled result register holds the input register, and a
// word can enter whenever the input register moves on. Header words 0 and 1
// give no result, word 2 gives a header or reject result, data words give a
// sample pair each. The limit registers are written through the cfg port and
// take effect on the next word decoded.
// ----------------------------------------------------------------------------
module digitizer_frame_unpacker_core #(
	parameter int CHANNELS_PER_MODULE = dfu_pkg::CHANNELS_PER_MODULE_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              word_valid,
	output logic                   word_ready,
	input  wire dfu_pkg::word_t    word,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output dfu_pkg::result_t       res,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [7:0]        cfg_data
);
	import dfu_pkg::*;

	cfg_t    cfg_q;
	logic    valid_s1;
	word_t   word_s1;
	logic    advance;
	logic    fire;
	logic    dec_valid;
	result_t dec_res;
	logic    res_valid_q;
	result_t res_q;

	assign advance    = !res_valid_q || res_ready;
	assign fire       = valid_s1 && advance;
	assign word_ready = !valid_s1 || advance;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_valid_q;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_modules <= MAX_MODULES_RST;
			cfg_q.max_samples <= MAX_SAMPLES_RST;
			cfg_q.max_slot    <= MAX_SLOT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_MODULES: cfg_q.max_modules <= cfg_data[2:0];
				CFG_MAX_SAMPLES: cfg_q.max_samples <= cfg_data[4:0];
				CFG_MAX_SLOT:    cfg_q.max_slot    <= cfg_data;
				default: begin
					// unknown index: drop the write
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (word_ready) begin
			valid_s1 <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (word_valid && word_ready) begin
			word_s1 <= word;
		end
	end

	dfu_frame #(
		.CHANNELS_PER_MODULE(CHANNELS_PER_MODULE)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (word_s1),
		.limits    (cfg_q),
		.res_valid (dec_valid),
		.res       (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= fire && dec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && dec_valid) begin
			res_q <= dec_res;
		end
	end

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(word_s1))
		else $error("input register lost a word while stalled");

	a_res_from_fire: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(fire))
		else $error("result appeared without a decoded word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !res_ready |=> res_valid_q && $stable(res_q))
		else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- design/dfu_frame.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dfu_frame
// Frame state and word decode: holds header fields and counters, and forms
// the result for the word in the input register.
// ----------------------------------------------------------------------------
module dfu_frame #(
	parameter int CHANNELS_PER_MODULE = dfu_pkg::CHANNELS_PER_MODULE_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire dfu_pkg::word_t  item,
	input  wire dfu_pkg::cfg_t   limits,
	output logic                 res_valid,
	output dfu_pkg::result_t     res
);
	import dfu_pkg::*;

	localparam int PROD_W = 8 + $clog2(CHANNELS_PER_MODULE + 1);
	localparam logic [1:0] HDR_LAST = 2'(HEADER_WORDS - 1);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_HEADER,
		MODE_DATA,
		MODE_DONE
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [1:0]  hdr_pos_q, hdr_pos_d;
	logic [7:0]  samples_q, delay_q, slot_q, modules_q;
	logic [7:0]  pair_cnt_q, pair_cnt_d;
	logic [4:0]  sample_cnt_q, sample_cnt_d;

	logic [PROD_W-1:0] ch_full;
	logic [PROD_W-1:0] pair_total;
	logic [4:0]        sample_next;
	logic [7:0]        pair_next;
	logic              bad;

	assign ch_full     = PROD_W'(modules_q) * PROD_W'(CHANNELS_PER_MODULE);
	assign pair_total  = ch_full >> 1;
	assign sample_next = sample_cnt_q + 5'd1;
	assign pair_next   = pair_cnt_q + 8'd1;
	assign bad = (modules_q > {5'd0, limits.max_modules})
		|| (samples_q > {3'd0, limits.max_samples})
		|| (slot_q > limits.max_slot);

	always_comb begin
		mode_d       = mode_q;
		hdr_pos_d    = hdr_pos_q;
		pair_cnt_d   = pair_cnt_q;
		sample_cnt_d = sample_cnt_q;
		res_valid    = 1'b0;
		res          = '0;
		if (item.frame_start) begin
			// restart: header word 0 is latched in the clocked block
			mode_d       = MODE_HEADER;
			hdr_pos_d    = 2'd1;
			pair_cnt_d   = '0;
			sample_cnt_d = '0;
		end else begin
			case (mode_q)
				MODE_HEADER: begin
					if (hdr_pos_q < HDR_LAST) begin
						hdr_pos_d = hdr_pos_q + 2'd1;
					end else begin
						res_valid         = 1'b1;
						res.kind          = bad ? KIND_REJECT : KIND_HEADER;
						res.sample_count  = samples_q;
						res.trigger_delay = delay_q;
						res.slot_number   = slot_q;
						res.module_count  = modules_q;
						res.channel_count = CHAN_COUNT_W'(ch_full);
						res.clock_stamp   = item.data_word[31:16];
						res.event_number  = item.data_word[15:0];
						hdr_pos_d    = '0;
						pair_cnt_d   = '0;
						sample_cnt_d = '0;
						if (bad || samples_q == 8'd0 || pair_total == '0) begin
							mode_d = MODE_DONE;
						end else begin
							mode_d = MODE_DATA;
						end
					end
				end
				MODE_DATA: begin
					res_valid         = 1'b1;
					res.kind          = KIND_PAIR;
					res.sample_index  = sample_cnt_q;
					res.channel_index = {pair_cnt_q, 1'b0};
					res.value_even    = item.data_word[15:0];
					res.value_odd     = item.data_word[31:16];
					sample_cnt_d      = sample_next;
					if ({3'd0, sample_next} >= samples_q || sample_next == 5'd0) begin
						// advance to the next channel pair
						sample_cnt_d = '0;
						pair_cnt_d   = pair_next;
						if (PROD_W'(pair_next) >= pair_total || pair_next == 8'd0) begin
							mode_d = MODE_DONE;
						end
					end
				end
				default: begin
					// idle or done: drop the word
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			hdr_pos_q    <= '0;
			samples_q    <= '0;
			delay_q      <= '0;
			slot_q       <= '0;
			modules_q    <= '0;
			pair_cnt_q   <= '0;
			sample_cnt_q <= '0;
		end else if (fire) begin
			mode_q       <= mode_d;
			hdr_pos_q    <= hdr_pos_d;
			pair_cnt_q   <= pair_cnt_d;
			sample_cnt_q <= sample_cnt_d;
			if (item.frame_start) begin
				samples_q <= item.data_word[31:24];
				delay_q   <= item.data_word[23:16];
				slot_q    <= item.data_word[15:8];
				modules_q <= item.data_word[7:0];
			end
		end
	end

	a_pair_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_DATA |-> PROD_W'(pair_cnt_q) < pair_total)
		else $error("pair counter past pair total in data mode");

	a_sample_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_DATA |-> {3'd0, sample_cnt_q} < samples_q)
		else $error("sample counter past sample count in data mode");

	a_header_pos: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_HEADER |-> hdr_pos_q != 2'd0)
		else $error("header mode with header position zero");

endmodule
`default_nettype wire

// ----- verif/digitizer_frame_unpacker_core_tb.sv -----
// ----------------------------------------------------------------------------
// digitizer_frame_unpacker_core_tb
// Self-checking bench for the digitizer subevent word unpacker.
// ----------------------------------------------------------------------------
// Streams subevent words through the core and predicts every header, reject
// and sample pair result from a behavioral copy of the frame state. Covers
// header limits at several limit settings, empty, truncated and overlong
// frames, restarts inside a frame, stray words, random idling on both sides
// and a long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module digitizer_frame_unpacker_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dfu_pkg::*;

	localparam int CPM = CHANNELS_PER_MODULE_DEF;

	typedef enum logic [1:0] {
		FRAME_IDLE,
		FRAME_HEADER,
		FRAME_DATA,
		FRAME_DONE
	} frame_mode_t;

	class unpack_scoreboard;
		logic [2:0]  lim_modules;
		logic [4:0]  lim_samples;
		logic [7:0]  lim_slot;
		logic [1:0]  hdr_pos;
		logic [7:0]  samples_held;
		logic [7:0]  modules_held;
		logic [7:0]  delay_held;
		logic [7:0]  slot_held;
		logic [7:0]  pair_ctr;
		logic [4:0]  samp_ctr;
		frame_mode_t mode;
		result_t     expected_results[$];
		int unsigned errors;
		int unsigned words_used;
		int unsigned n_headers;
		int unsigned n_rejects;
		int unsigned n_pairs;

		function new();
			lim_modules  = MAX_MODULES_RST;
			lim_samples  = MAX_SAMPLES_RST;
			lim_slot     = MAX_SLOT_RST;
			hdr_pos      = '0;
			samples_held = '0;
			modules_held = '0;
			delay_held   = '0;
			slot_held    = '0;
			pair_ctr     = '0;
			samp_ctr     = '0;
			mode         = FRAME_IDLE;
			errors       = 0;
			words_used   = 0;
			n_headers    = 0;
			n_rejects    = 0;
			n_pairs      = 0;
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction

		function void set_limit(logic [1:0] idx, logic [7:0] val);
			case (idx)
				CFG_MAX_MODULES: lim_modules = val[2:0];
				CFG_MAX_SAMPLES: lim_samples = val[4:0];
				CFG_MAX_SLOT:    lim_slot    = val;
				default: ;
			endcase
		endfunction

		// Advance the frame state by one accepted word and queue its result.
		function void note_word(word_t w);
			result_t     r;
			logic [31:0] d;
			int unsigned total;
			int unsigned chans;
			logic        bad;
			d = w.data_word;
			if (w.frame_start) begin
				samples_held = d[31:24];
				delay_held   = d[23:16];
				slot_held    = d[15:8];
				modules_held = d[7:0];
				hdr_pos      = 2'd1;
				pair_ctr     = '0;
				samp_ctr     = '0;
				mode         = FRAME_HEADER;
				words_used++;
				return;
			end
			chans = int'(modules_held) * CPM;
			total = chans / 2;
			case (mode)
				FRAME_HEADER: begin
					words_used++;
					if (hdr_pos + 1 < HEADER_WORDS) begin
						hdr_pos = hdr_pos + 2'd1;
					end else begin
						bad = (modules_held > lim_modules) || (samples_held > lim_samples) ||
							(slot_held > lim_slot);
						r = '0;
						r.kind          = bad ? KIND_REJECT : KIND_HEADER;
						r.sample_count  = samples_held;
						r.trigger_delay = delay_held;
						r.slot_number   = slot_held;
						r.module_count  = modules_held;
						r.channel_count = chans[CHAN_COUNT_W-1:0];
						r.clock_stamp   = d[31:16];
						r.event_number  = d[15:0];
						expected_results.push_back(r);
						if (bad)
							n_rejects++;
						else
							n_headers++;
						hdr_pos  = '0;
						pair_ctr = '0;
						samp_ctr = '0;
						if (bad || samples_held == 0 || total == 0)
							mode = FRAME_DONE;
						else
							mode = FRAME_DATA;
					end
				end
				FRAME_DATA: begin
					words_used++;
					r = '0;
					r.kind          = KIND_PAIR;
					r.sample_index  = samp_ctr;
					r.channel_index = {pair_ctr, 1'b0};
					r.value_even    = d[15:0];
					r.value_odd     = d[31:16];
					expected_results.push_back(r);
					n_pairs++;
					samp_ctr = samp_ctr + 5'd1;
					if (samp_ctr >= samples_held || samp_ctr == 0) begin
						samp_ctr = '0;
						pair_ctr = pair_ctr + 8'd1;
						if (pair_ctr >= total || pair_ctr == 0)
							mode = FRAME_DONE;
					end
				end
				default: ;
			endcase
		endfunction

		function void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
			if (exp_val !== act_val) begin
				errors++;
				$display("%0t ns: %s mismatch, expected %0h actual %0h",
					$time, name, exp_val, act_val);
			end
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected result, expected none actual %h", $time, r);
				return;
			end
			e = expected_results.pop_front();
			check_field("kind",          32'(e.kind),          32'(r.kind));
			check_field("sample_index",  32'(e.sample_index),  32'(r.sample_index));
			check_field("channel_index", 32'(e.channel_index), 32'(r.channel_index));
			check_field("value_even",    32'(e.value_even),    32'(r.value_even));
			check_field("value_odd",     32'(e.value_odd),     32'(r.value_odd));
			check_field("sample_count",  32'(e.sample_count),  32'(r.sample_count));
			check_field("trigger_delay", 32'(e.trigger_delay), 32'(r.trigger_delay));
			check_field("slot_number",   32'(e.slot_number),   32'(r.slot_number));
			check_field("module_count",  32'(e.module_count),  32'(r.module_count));
			check_field("channel_count", 32'(e.channel_count), 32'(r.channel_count));
			check_field("clock_stamp",   32'(e.clock_stamp),   32'(r.clock_stamp));
			check_field("event_number",  32'(e.event_number),  32'(r.event_number));
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       word_valid;
	logic       word_ready;
	word_t      word;
	logic       res_valid;
	logic       res_ready;
	result_t    res;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [1:0] cfg_index;
	logic [7:0] cfg_data;

	unpack_scoreboard sb;
	bit               gaps_on;
	bit               hold_req;
	int unsigned      words_sent;
	int unsigned      limit_sets;

	digitizer_frame_unpacker_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.word_valid (word_valid),
		.word_ready (word_ready),
		.word       (word),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("FAIL digitizer_frame_unpacker_core");
		$finish;
	end

	// Result side: random back-pressure, plus one long hold-off on request.
	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ready <= 1'b0;
				repeat (400) @(negedge clk);
			end
			res_ready <= !gaps_on || ($urandom_range(99, 0) >= 16);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_result(res);
	end

	function automatic word_t make_word(logic [31:0] d, logic s);
		word_t w;
		w.data_word   = d;
		w.frame_start = s;
		return w;
	endfunction

	function automatic logic [31:0] pair_word();
		int unsigned p;
		p = $urandom_range(19, 0);
		if (p == 0)
			return '0;
		if (p == 1)
			return '1;
		return $urandom();
	endfunction

	// Call at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input word_t w);
		while (gaps_on && $urandom_range(99, 0) < 16) begin
			word_valid <= 1'b0;
			@(negedge clk);
		end
		word_valid <= 1'b1;
		word       <= w;
		@(posedge clk);
		while (!word_ready) @(posedge clk);
		sb.note_word(w);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(input logic [31:0] hdr0, input logic [31:0] hdr2,
		input int unsigned hdr_words, input int unsigned n_data);
		send_word(make_word(hdr0, 1'b1));
		if (hdr_words > 1)
			send_word(make_word($urandom(), 1'b0));
		if (hdr_words > 2)
			send_word(make_word(hdr2, 1'b0));
		for (int unsigned i = 0; i < n_data; i++)
			send_word(make_word(pair_word(), 1'b0));
	endtask

	task automatic wait_idle();
		word_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Call only while the core is idle.
	task automatic set_limits(input logic [2:0] m, input logic [4:0] s, input logic [7:0] sl);
		logic [1:0] idx[3];
		logic [7:0] val[3];
		idx = '{CFG_MAX_MODULES, CFG_MAX_SAMPLES, CFG_MAX_SLOT};
		val = '{{5'd0, m}, {3'd0, s}, sl};
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data  <= val[k];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			sb.set_limit(idx[k], val[k]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		limit_sets++;
	endtask

	// Mostly well-formed small frames under the current limits; the rest
	// break a limit, stop early, run long or restart inside the header; some follow a stray word.
	task automatic random_frame();
		int unsigned mods;
		int unsigned smps;
		int unsigned slot;
		int unsigned hi;
		int unsigned n_data;
		int unsigned hdr_words;
		int unsigned pick;
		bit          ok;
		if ($urandom_range(19, 0) == 0)
			send_word(make_word($urandom(), 1'b0));
		hi   = (sb.lim_samples < 3) ? sb.lim_samples : 3;
		mods = (sb.lim_modules == 0) ? 0 :
			(($urandom_range(9, 0) == 0) ? $urandom_range(sb.lim_modules, 0) : 1);
		smps = (sb.lim_samples == 0) ? 0 :
			(($urandom_range(9, 0) == 0) ? $urandom_range(sb.lim_samples, 0) :
			$urandom_range(hi, 1));
		slot = $urandom_range(sb.lim_slot, 0);
		pick = $urandom_range(99, 0);
		if (pick < 8)
			mods = $urandom_range(255, 0);
		else if (pick < 16)
			smps = $urandom_range(255, 0);
		else if (pick < 22)
			slot = $urandom_range(255, 0);
		ok = (mods <= sb.lim_modules) && (smps <= sb.lim_samples) && (slot <= sb.lim_slot);
		hdr_words = 3;
		if (!ok) begin
			n_data = $urandom_range(2, 0);
		end else begin
			n_data = ((mods * CPM) / 2) * smps;
			pick = $urandom_range(99, 0);
			if (n_data > 256)
				n_data = $urandom_range(256, 1);
			else if (pick < 4) begin
				hdr_words = $urandom_range(2, 1);
				n_data = 0;
			end else if (pick < 14)
				n_data = $urandom_range(n_data, 0);
			else if (pick < 24)
				n_data = n_data + $urandom_range(3, 1);
		end
		send_frame({smps[7:0], 8'($urandom()), slot[7:0], mods[7:0]}, $urandom(),
			hdr_words, n_data);
	endtask

	task automatic run_phase(input int unsigned quota);
		int unsigned base;
		base = sb.words_used;
		while (sb.words_used - base < quota)
			random_frame();
		wait_idle();
	endtask

	initial begin
		arst_n     = 1'b0;
		word_valid = 1'b0;
		word       = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_MAX_MODULES;
		cfg_data   = '0;
		gaps_on    = 1'b1;
		hold_req   = 1'b0;
		words_sent = 0;
		limit_sets = 0;
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: stray word, restart mid-frame, each reject reason, empty frames.
		send_word(make_word(32'hFFFF_FFFF, 1'b0));
		send_frame({8'd2, 8'hFF, 8'd22, 8'd1}, 32'hFFFF_0000, 3, 0);
		send_word(make_word(32'h0000_0000, 1'b0));
		send_word(make_word(32'hFFFF_FFFF, 1'b0));
		send_word(make_word(32'h1234_5678, 1'b0));
		send_frame({8'd1, 8'd0, 8'd0, 8'd6}, 32'h0000_FFFF, 3, 1);
		send_frame(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3, 0);
		send_frame({8'd32, 8'd0, 8'd0, 8'd1}, 32'h0000_0000, 3, 0);
		send_frame({8'd1, 8'd0, 8'd23, 8'd1}, $urandom(), 3, 0);
		send_frame({8'd0, 8'd7, 8'd3, 8'd1}, $urandom(), 3, 1);
		send_frame({8'd3, 8'd1, 8'd2, 8'd0}, $urandom(), 3, 0);

		run_phase(400);

		set_limits(3'd0, 5'd0, 8'd0);
		run_phase(200);

		// No idling on either side; reach the last channel pair and last sample.
		set_limits(3'd5, 5'd31, 8'd255);
		gaps_on = 1'b0;
		send_frame({8'd1, 8'd0, 8'd255, 8'd5}, $urandom(), 3, 162);
		send_frame({8'd31, 8'd9, 8'd0, 8'd1}, $urandom(), 3, 62);
		run_phase(400);
		gaps_on = 1'b1;

		set_limits(3'($urandom_range(5, 1)), 5'($urandom_range(31, 1)),
			8'($urandom_range(255, 0)));
		hold_req = 1'b1;
		run_phase(500);

		set_limits(3'($urandom_range(5, 1)), 5'($urandom_range(31, 1)),
			8'($urandom_range(255, 0)));
		run_phase(500);

		$display("Streamed %0d words (%0d decoded) under %0d limit settings after reset:",
			words_sent, sb.words_used, limit_sets);
		$display("  %0d headers, %0d rejects, %0d sample pairs, with idling and a long hold-off.",
			sb.n_headers, sb.n_rejects, sb.n_pairs);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS digitizer_frame_unpacker_core");
		else
			$display("FAIL digitizer_frame_unpacker_core");
		$finish;
	end

endmodule
